/* rtl/core/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: request and result
// words, request codes, control bytes and the sequencer states.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int DEF_SCREEN_ROWS = 25;
	localparam int DEF_SCREEN_COLS = 80;

	localparam int CFG_AW = 3;
	localparam int CFG_DW = 32;

	// register index bit within paddr
	localparam logic REG_TEXT_COLOR    = 1'b0;
	localparam logic REG_CURSOR_HIDDEN = 1'b1;

	localparam logic [7:0] COLOR_MAX  = 8'h8F;
	localparam logic [7:0] CH_BS      = 8'h08;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_LF      = 8'h0A;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_PRINT_HI = 8'h7E;

	typedef enum logic [1:0] {
		REQ_PUT  = 2'd0,
		REQ_SET  = 2'd1,
		REQ_READ = 2'd2
	} req_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_COPY,
		ST_FILL,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] byte_in;
		logic [4:0] row_in;
		logic [6:0] col_in;
	} in_word_t;

	typedef struct packed {
		logic        status;
		logic [7:0]  cell_char;
		logic [7:0]  cell_attr;
		logic [4:0]  cur_row_out;
		logic [6:0]  cur_col_out;
		logic [10:0] hw_cursor_offset;
		logic        hw_cursor_update;
	} out_word_t;

endpackage

/* rtl/core/text_console_writer_top.sv */
// ----------------------------------------------------------------------------
// text_console_writer_top
// Text-mode screen engine: cell store, cursor, control characters, wrap and
// scroll, cursor placement and cell readback.
//
//   channel | dir | handshake             | payload
//   --------+-----+-----------------------+----------------------
//   in      | in  | in_valid / in_stall   | in_data  (in_word_t)
//   out     | out | out_valid / out_stall | out_data (out_word_t)
//   cfg     | in  | psel/penable/pwrite   | paddr, pwdata, prdata
//
// put byte and set cursor end in ST_EXEC if the output is free, read
// cell also passes ST_RESULT (one memory read). a put byte that scrolls
// walks the whole cell store through the single memory port pair in
// ST_COPY and ST_FILL. after reset a clearing pass writes every cell
// before the first word is taken.
// a stalled output holds the finished word; one more word may be taken
// and is held in the sequencer until the output register frees.
// ----------------------------------------------------------------------------
module text_console_writer_top #(
	parameter int SCREEN_ROWS = tcw_pkg::DEF_SCREEN_ROWS,
	parameter int SCREEN_COLS = tcw_pkg::DEF_SCREEN_COLS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  tcw_pkg::in_word_t         in_data,
	output logic                      out_valid,
	input  logic                      out_stall,
	output tcw_pkg::out_word_t        out_data,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [tcw_pkg::CFG_AW-1:0] paddr,
	input  logic [tcw_pkg::CFG_DW-1:0] pwdata,
	output logic [tcw_pkg::CFG_DW-1:0] prdata,
	output logic                      pready
);
	import tcw_pkg::*;

	localparam int CELLS = SCREEN_ROWS * SCREEN_COLS;
	localparam int RW    = $clog2(SCREEN_ROWS);
	localparam int CW    = $clog2(SCREEN_COLS);
	localparam int LW    = $clog2(CELLS);

	state_t state_q, state_d;

	logic [7:0]    text_color_q;
	logic          cursor_hidden_q;
	logic [RW-1:0] row_q, row_n;
	logic [CW-1:0] col_q, col_n;
	logic [LW-1:0] lin_q, lin_n;
	logic [LW-1:0] cnt_q, cnt_d;
	in_word_t      req_q;
	out_word_t     res_q, res_d, out_q, out_next;
	logic          res_rd_q, rd_cell;
	logic          out_valid_q, load_out, out_free;
	logic          cp_vld_s1;
	logic [LW-1:0] cp_addr_s1;

	logic          we, re;
	logic [LW-1:0] waddr, raddr;
	logic [15:0]   wdata, rdata;

	logic          cfg_wr;

	tcw_cell_mem #(
		.DEPTH(CELLS),
		.AW   (LW)
	) u_mem (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q    <= '0;
			cursor_hidden_q <= 1'b1;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_TEXT_COLOR) begin
				text_color_q <= pwdata[7:0];
			end else begin
				cursor_hidden_q <= pwdata[0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == REG_CURSOR_HIDDEN) begin
			prdata = {{(CFG_DW-1){1'b0}}, cursor_hidden_q};
		end else begin
			prdata = {{(CFG_DW-8){1'b0}}, text_color_q};
		end
	end

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// sequencer
	always_comb begin
		logic          last_col;
		logic          last_row;
		logic          color_ok;
		logic          in_range;
		logic          advance;
		logic          do_scroll;
		logic          status_d;
		logic          moved;
		logic [LW-1:0] set_lin;
		logic [31:0]   row_w;
		logic [31:0]   col_w;
		logic [31:0]   off_w;

		last_col  = (col_q == CW'(SCREEN_COLS - 1));
		last_row  = (row_q == RW'(SCREEN_ROWS - 1));
		color_ok  = (text_color_q <= COLOR_MAX);
		in_range  = (32'(req_q.row_in) < SCREEN_ROWS) && (32'(req_q.col_in) < SCREEN_COLS);
		set_lin   = LW'(32'(req_q.row_in) * SCREEN_COLS + 32'(req_q.col_in));
		advance   = 1'b0;
		do_scroll = 1'b0;
		status_d  = 1'b0;

		state_d  = state_q;
		cnt_d    = cnt_q;
		row_n    = row_q;
		col_n    = col_q;
		lin_n    = lin_q;
		rd_cell  = 1'b0;
		in_stall = 1'b1;
		load_out = 1'b0;
		out_next = res_q;
		we       = 1'b0;
		waddr    = cnt_q;
		wdata    = '0;
		re       = 1'b0;
		raddr    = cnt_q;

		// scroll copy write, issued in the cycle after its read
		if (cp_vld_s1) begin
			we    = 1'b1;
			waddr = cp_addr_s1;
			wdata = rdata;
		end

		if (state_q == ST_EXEC) begin
			unique case (req_q.req_type)
				REQ_PUT: begin
					unique case (req_q.byte_in)
						CH_BS: begin
							if (!(col_q == '0 && row_q == '0)) begin
								if (color_ok) begin
									we    = 1'b1;
									waddr = LW'(32'(lin_q) - 1);
									wdata = {text_color_q, CH_SPACE};
								end
								if (col_q == '0) begin
									row_n = RW'(32'(row_q) - 1);
									col_n = CW'(SCREEN_COLS - 1);
								end else begin
									col_n = CW'(32'(col_q) - 1);
								end
								lin_n = LW'(32'(lin_q) - 1);
							end
						end
						CH_CR: begin
							col_n = '0;
							lin_n = LW'(32'(lin_q) - 32'(col_q));
						end
						CH_LF: begin
							advance = 1'b1;
						end
						default: begin
							if (req_q.byte_in >= CH_SPACE && req_q.byte_in <= CH_PRINT_HI
									&& color_ok) begin
								we    = 1'b1;
								waddr = lin_q;
								wdata = {text_color_q, req_q.byte_in};
							end
							if (last_col) begin
								advance = 1'b1;
							end else begin
								col_n = CW'(32'(col_q) + 1);
								lin_n = LW'(32'(lin_q) + 1);
							end
						end
					endcase
					if (advance) begin
						col_n = '0;
						if (last_row) begin
							do_scroll = 1'b1;
							lin_n     = LW'(CELLS - SCREEN_COLS);
						end else begin
							row_n = RW'(32'(row_q) + 1);
							lin_n = LW'(32'(lin_q) - 32'(col_q) + SCREEN_COLS);
						end
					end
				end
				REQ_SET: begin
					if (in_range) begin
						row_n = RW'(req_q.row_in);
						col_n = CW'(req_q.col_in);
						lin_n = set_lin;
					end else begin
						status_d = 1'b1;
					end
				end
				REQ_READ: begin
					if (in_range) begin
						re      = 1'b1;
						raddr   = set_lin;
						rd_cell = 1'b1;
					end else begin
						status_d = 1'b1;
					end
				end
				default: begin
					status_d = 1'b1;
				end
			endcase
		end

		moved = (row_n != row_q) || (col_n != col_q);
		row_w = 32'(row_n);
		col_w = 32'(col_n);
		off_w = cursor_hidden_q ? 32'(CELLS) : 32'(lin_n);
		res_d.status           = status_d;
		res_d.cell_char        = '0;
		res_d.cell_attr        = '0;
		res_d.cur_row_out      = row_w[4:0];
		res_d.cur_col_out      = col_w[6:0];
		res_d.hw_cursor_offset = off_w[10:0];
		res_d.hw_cursor_update = !cursor_hidden_q && moved;

		unique case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = cnt_q;
				wdata = '0;
				if (cnt_q == LW'(CELLS - 1)) begin
					cnt_d   = '0;
					state_d = ST_IDLE;
				end else begin
					cnt_d = LW'(32'(cnt_q) + 1);
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (do_scroll) begin
					cnt_d   = LW'(SCREEN_COLS);
					state_d = ST_COPY;
				end else if (rd_cell) begin
					state_d = ST_RESULT;
				end else if (out_free) begin
					load_out = 1'b1;
					out_next = res_d;
					state_d  = ST_IDLE;
				end else begin
					state_d = ST_RESULT;
				end
			end
			ST_COPY: begin
				re    = 1'b1;
				raddr = cnt_q;
				if (cnt_q == LW'(CELLS - 1)) begin
					cnt_d   = LW'(CELLS - SCREEN_COLS);
					state_d = ST_FILL;
				end else begin
					cnt_d = LW'(32'(cnt_q) + 1);
				end
			end
			ST_FILL: begin
				// the last copy write still owns the write port on entry to ST_FILL
				if (!cp_vld_s1) begin
					we    = 1'b1;
					waddr = cnt_q;
					wdata = {text_color_q, CH_SPACE};
					if (cnt_q == LW'(CELLS - 1)) begin
						cnt_d   = '0;
						state_d = ST_RESULT;
					end else begin
						cnt_d = LW'(32'(cnt_q) + 1);
					end
				end
			end
			ST_RESULT: begin
				out_next = res_q;
				if (res_rd_q) begin
					out_next.cell_char = rdata[7:0];
					out_next.cell_attr = rdata[15:8];
				end
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cnt_q       <= '0;
			row_q       <= '0;
			col_q       <= '0;
			lin_q       <= '0;
			out_valid_q <= 1'b0;
			cp_vld_s1   <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			cp_vld_s1 <= (state_q == ST_COPY);
			if (state_q == ST_EXEC) begin
				row_q <= row_n;
				col_q <= col_n;
				lin_q <= lin_n;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cp_addr_s1 <= LW'(32'(cnt_q) - SCREEN_COLS);
		if (state_q == ST_IDLE && in_valid) begin
			req_q <= in_data;
		end
		if (state_q == ST_EXEC) begin
			res_q    <= res_d;
			res_rd_q <= rd_cell;
		end
		if (load_out) begin
			out_q <= out_next;
		end
	end

endmodule

/* rtl/core/tcw_cell_mem.sv */
// ----------------------------------------------------------------------------
// tcw_cell_mem
// Screen cell store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tcw_cell_mem #(
	parameter int DEPTH = 2000,
	parameter int AW    = 11
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [15:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [15:0]   rdata
);
	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
